/* rtl/qgi_pkg.sv */
// Package: shared types, widths and the micro-op table of the gyro integrator.
`timescale 1ns / 1ps
package qgi_pkg;

  // Field and datapath widths
  localparam int RATE_W      = 23;
  localparam int DT_W        = 24;
  localparam int QUAT_W      = 32;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 288;
  localparam int N_ENTRIES   = 9;
  localparam int OPND_W      = 33;
  localparam int PROD_W      = 2 * OPND_W;
  localparam int ACC_W       = 74;
  localparam int H_W         = 40;
  localparam int NQ_W        = 40;
  localparam int MAG_W       = 31;
  localparam int RAD_W       = 64;
  localparam int ROOT_W      = 32;
  localparam int K_W         = 4;
  localparam int STEP_W      = 6;

  localparam logic signed [RATE_W-1:0] RATE_LIMIT = 23'sd2293760;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_SCALE,
    ST_ROOT,
    ST_ROOT_WAIT,
    ST_DIV,
    ST_DIV_WAIT,
    ST_OUT
  } state_t;

  // Operand selects for the shared multiplier
  typedef enum logic [4:0] {
    OP_QW, OP_QX, OP_QY, OP_QZ,
    OP_RX, OP_RY, OP_RZ, OP_DT,
    OP_HIX, OP_HIY, OP_HIZ,
    OP_LOX, OP_LOY, OP_LOZ,
    OP_M0, OP_M1, OP_M2, OP_M3
  } opnd_t;

  // Product alignment before accumulation
  typedef enum logic [1:0] {
    SH_NONE,
    SH_ONE,
    SH_BYTE
  } shift_t;

  // Where a finished accumulation is written
  typedef enum logic [4:0] {
    WB_NONE,
    WB_HX, WB_HY, WB_HZ,
    WB_NQ0, WB_NQ1, WB_NQ2, WB_NQ3,
    WB_SUMSQ,
    WB_M0, WB_M1, WB_M2, WB_M3, WB_M4, WB_M5, WB_M6, WB_M7, WB_M8
  } wb_t;

  typedef struct packed {
    opnd_t  a;
    opnd_t  b;
    logic   neg;
    shift_t sh;
    logic   clr;
    wb_t    wb;
  } uop_t;

  // Control beat from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic                     mul_en;
    logic                     acc_en;
    logic signed [OPND_W-1:0] a;
    logic signed [OPND_W-1:0] b;
    logic                     neg;
    shift_t                   sh;
    logic                     clr;
  } mac_ctl_t;

  function automatic uop_t mk(input opnd_t a, input opnd_t b, input logic neg,
                              input shift_t sh, input logic clr, input wb_t wb);
    uop_t u;
    u.a   = a;
    u.b   = b;
    u.neg = neg;
    u.sh  = sh;
    u.clr = clr;
    u.wb  = wb;
    return u;
  endfunction

  // Micro-op program: half angles, quaternion update, squares, matrix
  function automatic uop_t uop_at(input logic [STEP_W-1:0] s);
    uop_t u;
    case (s)
      // half angles: rate * dt
      6'd0:  u = mk(OP_RX, OP_DT, 1'b0, SH_NONE, 1'b1, WB_HX);
      6'd1:  u = mk(OP_RY, OP_DT, 1'b0, SH_NONE, 1'b1, WB_HY);
      6'd2:  u = mk(OP_RZ, OP_DT, 1'b0, SH_NONE, 1'b1, WB_HZ);
      // w' = w - x hx - y hy - z hz
      6'd3:  u = mk(OP_QX, OP_HIX, 1'b1, SH_BYTE, 1'b1, WB_NONE);
      6'd4:  u = mk(OP_QX, OP_LOX, 1'b1, SH_NONE, 1'b0, WB_NONE);
      6'd5:  u = mk(OP_QY, OP_HIY, 1'b1, SH_BYTE, 1'b0, WB_NONE);
      6'd6:  u = mk(OP_QY, OP_LOY, 1'b1, SH_NONE, 1'b0, WB_NONE);
      6'd7:  u = mk(OP_QZ, OP_HIZ, 1'b1, SH_BYTE, 1'b0, WB_NONE);
      6'd8:  u = mk(OP_QZ, OP_LOZ, 1'b1, SH_NONE, 1'b0, WB_NQ0);
      // x' = x + w hx + y hz - z hy
      6'd9:  u = mk(OP_QW, OP_HIX, 1'b0, SH_BYTE, 1'b1, WB_NONE);
      6'd10: u = mk(OP_QW, OP_LOX, 1'b0, SH_NONE, 1'b0, WB_NONE);
      6'd11: u = mk(OP_QY, OP_HIZ, 1'b0, SH_BYTE, 1'b0, WB_NONE);
      6'd12: u = mk(OP_QY, OP_LOZ, 1'b0, SH_NONE, 1'b0, WB_NONE);
      6'd13: u = mk(OP_QZ, OP_HIY, 1'b1, SH_BYTE, 1'b0, WB_NONE);
      6'd14: u = mk(OP_QZ, OP_LOY, 1'b1, SH_NONE, 1'b0, WB_NQ1);
      // y' = y + w hy - x hz + z hx
      6'd15: u = mk(OP_QW, OP_HIY, 1'b0, SH_BYTE, 1'b1, WB_NONE);
      6'd16: u = mk(OP_QW, OP_LOY, 1'b0, SH_NONE, 1'b0, WB_NONE);
      6'd17: u = mk(OP_QX, OP_HIZ, 1'b1, SH_BYTE, 1'b0, WB_NONE);
      6'd18: u = mk(OP_QX, OP_LOZ, 1'b1, SH_NONE, 1'b0, WB_NONE);
      6'd19: u = mk(OP_QZ, OP_HIX, 1'b0, SH_BYTE, 1'b0, WB_NONE);
      6'd20: u = mk(OP_QZ, OP_LOX, 1'b0, SH_NONE, 1'b0, WB_NQ2);
      // z' = z + w hz + x hy - y hx
      6'd21: u = mk(OP_QW, OP_HIZ, 1'b0, SH_BYTE, 1'b1, WB_NONE);
      6'd22: u = mk(OP_QW, OP_LOZ, 1'b0, SH_NONE, 1'b0, WB_NONE);
      6'd23: u = mk(OP_QX, OP_HIY, 1'b0, SH_BYTE, 1'b0, WB_NONE);
      6'd24: u = mk(OP_QX, OP_LOY, 1'b0, SH_NONE, 1'b0, WB_NONE);
      6'd25: u = mk(OP_QY, OP_HIX, 1'b1, SH_BYTE, 1'b0, WB_NONE);
      6'd26: u = mk(OP_QY, OP_LOX, 1'b1, SH_NONE, 1'b0, WB_NQ3);
      // sum of squares of scaled magnitudes
      6'd27: u = mk(OP_M0, OP_M0, 1'b0, SH_NONE, 1'b1, WB_NONE);
      6'd28: u = mk(OP_M1, OP_M1, 1'b0, SH_NONE, 1'b0, WB_NONE);
      6'd29: u = mk(OP_M2, OP_M2, 1'b0, SH_NONE, 1'b0, WB_NONE);
      6'd30: u = mk(OP_M3, OP_M3, 1'b0, SH_NONE, 1'b0, WB_SUMSQ);
      // rotation matrix
      6'd31: u = mk(OP_QW, OP_QW, 1'b0, SH_NONE, 1'b1, WB_NONE);
      6'd32: u = mk(OP_QX, OP_QX, 1'b0, SH_NONE, 1'b0, WB_NONE);
      6'd33: u = mk(OP_QY, OP_QY, 1'b1, SH_NONE, 1'b0, WB_NONE);
      6'd34: u = mk(OP_QZ, OP_QZ, 1'b1, SH_NONE, 1'b0, WB_M0);
      6'd35: u = mk(OP_QX, OP_QY, 1'b0, SH_ONE, 1'b1, WB_NONE);
      6'd36: u = mk(OP_QW, OP_QZ, 1'b1, SH_ONE, 1'b0, WB_M1);
      6'd37: u = mk(OP_QX, OP_QZ, 1'b0, SH_ONE, 1'b1, WB_NONE);
      6'd38: u = mk(OP_QW, OP_QY, 1'b0, SH_ONE, 1'b0, WB_M2);
      6'd39: u = mk(OP_QX, OP_QY, 1'b0, SH_ONE, 1'b1, WB_NONE);
      6'd40: u = mk(OP_QW, OP_QZ, 1'b0, SH_ONE, 1'b0, WB_M3);
      6'd41: u = mk(OP_QW, OP_QW, 1'b0, SH_NONE, 1'b1, WB_NONE);
      6'd42: u = mk(OP_QX, OP_QX, 1'b1, SH_NONE, 1'b0, WB_NONE);
      6'd43: u = mk(OP_QY, OP_QY, 1'b0, SH_NONE, 1'b0, WB_NONE);
      6'd44: u = mk(OP_QZ, OP_QZ, 1'b1, SH_NONE, 1'b0, WB_M4);
      6'd45: u = mk(OP_QY, OP_QZ, 1'b0, SH_ONE, 1'b1, WB_NONE);
      6'd46: u = mk(OP_QW, OP_QX, 1'b1, SH_ONE, 1'b0, WB_M5);
      6'd47: u = mk(OP_QX, OP_QZ, 1'b0, SH_ONE, 1'b1, WB_NONE);
      6'd48: u = mk(OP_QW, OP_QY, 1'b1, SH_ONE, 1'b0, WB_M6);
      6'd49: u = mk(OP_QY, OP_QZ, 1'b0, SH_ONE, 1'b1, WB_NONE);
      6'd50: u = mk(OP_QW, OP_QX, 1'b0, SH_ONE, 1'b0, WB_M7);
      6'd51: u = mk(OP_QW, OP_QW, 1'b0, SH_NONE, 1'b1, WB_NONE);
      6'd52: u = mk(OP_QX, OP_QX, 1'b1, SH_NONE, 1'b0, WB_NONE);
      6'd53: u = mk(OP_QY, OP_QY, 1'b1, SH_NONE, 1'b0, WB_NONE);
      6'd54: u = mk(OP_QZ, OP_QZ, 1'b0, SH_NONE, 1'b0, WB_M8);
      default: u = mk(OP_QW, OP_QW, 1'b0, SH_NONE, 1'b1, WB_NONE);
    endcase
    return u;
  endfunction

endpackage

/* rtl/qgi_mac.sv */
// Shared signed multiply-accumulate unit with a registered product.
`timescale 1ns / 1ps
module qgi_mac (
  input  logic                          clk,
  input  qgi_pkg::mac_ctl_t             ctl,
  output logic signed [qgi_pkg::ACC_W-1:0] acc
);
  import qgi_pkg::*;

  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W-1:0]  pext, pshift, base;

  // product stage
  always_comb begin
    prod_nxt = ctl.mul_en ? ctl.a * ctl.b : prod_r;
  end

  // align, sign and accumulate
  always_comb begin
    pext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    case (ctl.sh)
      SH_NONE: pshift = pext;
      SH_ONE:  pshift = pext <<< 1;
      SH_BYTE: pshift = pext <<< 8;
      default: pshift = pext;
    endcase
    base = ctl.clr ? '0 : acc_r;
    if (!ctl.acc_en) begin
      acc_nxt = acc_r;
    end else if (ctl.neg) begin
      acc_nxt = base - pshift;
    end else begin
      acc_nxt = base + pshift;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

/* rtl/qgi_sqrt.sv */
// Iterative integer square root, one root bit per cycle.
`timescale 1ns / 1ps
module qgi_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [qgi_pkg::RAD_W-1:0]     radicand,
  output logic                          done,
  output logic [qgi_pkg::ROOT_W-1:0]    root
);
  import qgi_pkg::*;

  localparam int REM_W = ROOT_W + 4;
  localparam int CNT_W = $clog2(ROOT_W);

  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [REM_W-1:0]  rem_sh, trial;

  // one restoring step per cycle
  always_comb begin
    rem_sh   = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
    trial    = {2'b00, root_r, 2'b01};
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CNT_W'(ROOT_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = rad_r << 2;
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

/* rtl/qgi_div.sv */
// Iterative restoring divider: round(mag * 2^QUAT_FRAC_BITS / den), one bit per cycle.
`timescale 1ns / 1ps
module qgi_div #(
  parameter int QUAT_FRAC_BITS = 30
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [qgi_pkg::MAG_W-1:0]     mag,
  input  logic [qgi_pkg::ROOT_W-1:0]    den,
  output logic                          done,
  output logic [qgi_pkg::QUAT_W-1:0]    quo
);
  import qgi_pkg::*;

  localparam int QB    = QUAT_FRAC_BITS + 1;
  localparam int CNT_W = $clog2(QB);
  localparam int DVD_W = 64;

  logic [QB-1:0]     dl_r, dl_nxt;
  logic [QB-1:0]     q_r, q_nxt;
  logic [ROOT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DVD_W-1:0]  dvd, dvd_hi;
  logic [ROOT_W:0]   rem_sh;

  // dividend carries the rounding half of the denominator
  always_comb begin
    dvd    = (DVD_W'(mag) << QUAT_FRAC_BITS) + DVD_W'(den >> 1);
    dvd_hi = dvd >> QB;
    rem_sh = {rem_r, dl_r[QB-1]};
    dl_nxt   = dl_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dl_nxt   = dvd[QB-1:0];
      rem_nxt  = dvd_hi[ROOT_W-1:0];
      q_nxt    = '0;
      cnt_nxt  = CNT_W'(QB - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dl_nxt = dl_r << 1;
      if (rem_sh >= {1'b0, den}) begin
        rem_nxt = ROOT_W'(rem_sh - {1'b0, den});
        q_nxt   = {q_r[QB-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[ROOT_W-1:0];
        q_nxt   = {q_r[QB-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dl_r  <= dl_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quo  = QUAT_W'(q_r);

endmodule

/* rtl/quaternion_gyro_integrator.sv */
// Top level: quaternion gyro integrator with rotation matrix output.
//
//  Channel | Group  | Payload (low bits first)
//  input   | in_*   | rate_x[23], rate_y[23], rate_z[23], time_step[24], pad to 96
//  output  | out_*  | m00..m22, 32 bits each, row then column
//
// One sample runs through 3 half-angle products, 24 update products and 4 squares
// on the shared multiply-accumulate unit, a square root, four divides, 24 more
// products for the matrix, then the result beat. A tiny norm skips root and divides.
// in_tready is high only while idle; the result beat holds until out_tready.
// Reset (rst_n low, synchronous) sets the attitude to identity.
`timescale 1ns / 1ps
module quaternion_gyro_integrator #(
  parameter int QUAT_FRAC_BITS = 30
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // rate_x, rate_y, rate_z, time_step
  input  logic [qgi_pkg::IN_TDATA_W-1:0]       in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22
  output logic [qgi_pkg::OUT_TDATA_W-1:0]      out_tdata
);
  import qgi_pkg::*;

  localparam int HS = 41 - QUAT_FRAC_BITS;
  localparam logic signed [QUAT_W-1:0] ONE_Q = QUAT_W'(1) <<< QUAT_FRAC_BITS;
  localparam logic signed [ACC_W-1:0]  ONE_E = ACC_W'(1) <<< QUAT_FRAC_BITS;
  localparam logic signed [ACC_W-1:0]  RND_E = ACC_W'(1) <<< (QUAT_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0]  RND_H = ACC_W'(1) <<< (HS - 1);
  localparam logic [RAD_W-1:0] TINY_SUMSQ =
    (64'd1 << (2 * QUAT_FRAC_BITS)) / 64'd1000000000000;

  state_t state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [1:0]        sub_r, sub_nxt;
  logic [K_W-1:0]    k_r, k_nxt;
  logic [1:0]        didx_r, didx_nxt;

  logic signed [RATE_W-1:0] rate_r [3];
  logic signed [RATE_W-1:0] rate_nxt [3];
  logic [DT_W-1:0]          dt_r, dt_nxt;
  logic signed [H_W-1:0]    h_r [3];
  logic signed [H_W-1:0]    h_nxt [3];
  logic signed [NQ_W-1:0]   nq_r [4];
  logic signed [NQ_W-1:0]   nq_nxt [4];
  logic signed [QUAT_W-1:0] quat_r [4];
  logic signed [QUAT_W-1:0] quat_nxt [4];
  logic signed [QUAT_W-1:0] mout_r [N_ENTRIES];
  logic signed [QUAT_W-1:0] mout_nxt [N_ENTRIES];

  uop_t                     cur;
  logic                     op_end, in_hs, tiny;
  mac_ctl_t                 mac_ctl;
  logic signed [ACC_W-1:0]  acc;
  logic signed [OPND_W-1:0] opa, opb;
  logic [NQ_W-1:0]          mag [4];
  logic [MAG_W-1:0]         mag_sh [4];
  logic [NQ_W-1:0]          mx;
  logic [K_W-1:0]           k_calc;
  logic signed [ACC_W-1:0]  h_t, h_v, nq_v, em_t, em_v;
  logic signed [QUAT_W-1:0] em_sat;
  logic                     sq_start, sq_done, dv_start, dv_done;
  logic [ROOT_W-1:0]        root;
  logic [QUAT_W-1:0]        quo;

  function automatic logic signed [RATE_W-1:0] sat_rate(input logic signed [RATE_W-1:0] r);
    if (r > RATE_LIMIT) begin
      return RATE_LIMIT;
    end else if (r < -RATE_LIMIT) begin
      return -RATE_LIMIT;
    end
    return r;
  endfunction

  function automatic logic signed [OPND_W-1:0] sx_q(input logic signed [QUAT_W-1:0] q);
    return {{(OPND_W-QUAT_W){q[QUAT_W-1]}}, q};
  endfunction

  assign in_hs = in_tvalid && in_tready;
  assign cur   = uop_at(step_r);
  assign op_end = (sub_r == 2'd1 && cur.wb == WB_NONE) || (sub_r == 2'd2);

  // magnitudes, largest magnitude and scale shift
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i]    = nq_r[i][NQ_W-1] ? NQ_W'(-nq_r[i]) : NQ_W'(nq_r[i]);
      mag_sh[i] = MAG_W'(mag[i] >> k_r);
    end
    mx = mag[0];
    for (int i = 1; i < 4; i++) begin
      if (mag[i] > mx) mx = mag[i];
    end
    k_calc = '0;
    for (int j = 8; j >= 0; j--) begin
      if ((mx >> j) < (NQ_W'(1) << 31)) k_calc = K_W'(j);
    end
  end

  assign tiny = (k_r == '0) && (acc[RAD_W-1:0] <= TINY_SUMSQ);

  // operand selection
  function automatic logic signed [OPND_W-1:0] pick(input opnd_t s);
    case (s)
      OP_QW:   return sx_q(quat_r[0]);
      OP_QX:   return sx_q(quat_r[1]);
      OP_QY:   return sx_q(quat_r[2]);
      OP_QZ:   return sx_q(quat_r[3]);
      OP_RX:   return OPND_W'(rate_r[0]);
      OP_RY:   return OPND_W'(rate_r[1]);
      OP_RZ:   return OPND_W'(rate_r[2]);
      OP_DT:   return {{(OPND_W-DT_W){1'b0}}, dt_r};
      OP_HIX:  return OPND_W'(h_r[0] >>> 8);
      OP_HIY:  return OPND_W'(h_r[1] >>> 8);
      OP_HIZ:  return OPND_W'(h_r[2] >>> 8);
      OP_LOX:  return {{(OPND_W-8){1'b0}}, h_r[0][7:0]};
      OP_LOY:  return {{(OPND_W-8){1'b0}}, h_r[1][7:0]};
      OP_LOZ:  return {{(OPND_W-8){1'b0}}, h_r[2][7:0]};
      OP_M0:   return {{(OPND_W-MAG_W){1'b0}}, mag_sh[0]};
      OP_M1:   return {{(OPND_W-MAG_W){1'b0}}, mag_sh[1]};
      OP_M2:   return {{(OPND_W-MAG_W){1'b0}}, mag_sh[2]};
      OP_M3:   return {{(OPND_W-MAG_W){1'b0}}, mag_sh[3]};
      default: return '0;
    endcase
  endfunction

  // operands follow both the micro-op and the registers it selects
  always_comb begin
    opa = pick(cur.a);
    opb = pick(cur.b);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_hs) state_nxt = ST_MAC;
      end
      ST_MAC: begin
        if (op_end) begin
          case (cur.wb)
            WB_NQ3:   state_nxt = ST_SCALE;
            WB_SUMSQ: state_nxt = tiny ? ST_MAC : ST_ROOT;
            WB_M8:    state_nxt = ST_OUT;
            default:  state_nxt = ST_MAC;
          endcase
        end
      end
      ST_SCALE:     state_nxt = ST_MAC;
      ST_ROOT:      state_nxt = ST_ROOT_WAIT;
      ST_ROOT_WAIT: begin
        if (sq_done) state_nxt = ST_DIV;
      end
      ST_DIV:       state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (dv_done) state_nxt = (didx_r == 2'd3) ? ST_MAC : ST_DIV;
      end
      ST_OUT: begin
        if (out_tready) state_nxt = ST_IDLE;
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready      = (state_r == ST_IDLE);
    out_tvalid     = (state_r == ST_OUT);
    sq_start       = (state_r == ST_ROOT);
    dv_start       = (state_r == ST_DIV);
    mac_ctl.mul_en = (state_r == ST_MAC) && (sub_r == 2'd0);
    mac_ctl.acc_en = (state_r == ST_MAC) && (sub_r == 2'd1);
    mac_ctl.a      = opa;
    mac_ctl.b      = opb;
    mac_ctl.neg    = cur.neg;
    mac_ctl.sh     = cur.sh;
    mac_ctl.clr    = cur.clr;
  end

  // writeback arithmetic
  always_comb begin
    h_t  = acc + RND_H;
    h_v  = h_t >>> HS;
    nq_v = acc >>> QUAT_FRAC_BITS;
    em_t = acc + RND_E;
    em_v = em_t >>> QUAT_FRAC_BITS;
    if (em_v > ONE_E) begin
      em_sat = ONE_Q;
    end else if (em_v < -ONE_E) begin
      em_sat = -ONE_Q;
    end else begin
      em_sat = em_v[QUAT_W-1:0];
    end
  end

  // datapath and counters
  always_comb begin
    step_nxt = step_r;
    sub_nxt  = sub_r;
    k_nxt    = k_r;
    didx_nxt = didx_r;
    dt_nxt   = dt_r;
    rate_nxt = rate_r;
    h_nxt    = h_r;
    nq_nxt   = nq_r;
    quat_nxt = quat_r;
    mout_nxt = mout_r;
    case (state_r)
      ST_IDLE: begin
        if (in_hs) begin
          rate_nxt[0] = sat_rate(in_tdata[22:0]);
          rate_nxt[1] = sat_rate(in_tdata[45:23]);
          rate_nxt[2] = sat_rate(in_tdata[68:46]);
          dt_nxt      = in_tdata[92:69];
          step_nxt    = '0;
          sub_nxt     = '0;
          didx_nxt    = '0;
        end
      end
      ST_MAC: begin
        sub_nxt = op_end ? 2'd0 : sub_r + 2'd1;
        if (op_end) step_nxt = step_r + 1'b1;
        if (sub_r == 2'd2) begin
          case (cur.wb)
            WB_HX:  h_nxt[0] = h_v[H_W-1:0];
            WB_HY:  h_nxt[1] = h_v[H_W-1:0];
            WB_HZ:  h_nxt[2] = h_v[H_W-1:0];
            WB_NQ0: nq_nxt[0] = NQ_W'(quat_r[0]) + nq_v[NQ_W-1:0];
            WB_NQ1: nq_nxt[1] = NQ_W'(quat_r[1]) + nq_v[NQ_W-1:0];
            WB_NQ2: nq_nxt[2] = NQ_W'(quat_r[2]) + nq_v[NQ_W-1:0];
            WB_NQ3: nq_nxt[3] = NQ_W'(quat_r[3]) + nq_v[NQ_W-1:0];
            WB_M0:  mout_nxt[0] = em_sat;
            WB_M1:  mout_nxt[1] = em_sat;
            WB_M2:  mout_nxt[2] = em_sat;
            WB_M3:  mout_nxt[3] = em_sat;
            WB_M4:  mout_nxt[4] = em_sat;
            WB_M5:  mout_nxt[5] = em_sat;
            WB_M6:  mout_nxt[6] = em_sat;
            WB_M7:  mout_nxt[7] = em_sat;
            WB_M8:  mout_nxt[8] = em_sat;
            default: ;
          endcase
        end
      end
      ST_SCALE: k_nxt = k_calc;
      ST_DIV_WAIT: begin
        if (dv_done) begin
          quat_nxt[didx_r] = nq_r[didx_r][NQ_W-1] ? -quo : quo;
          didx_nxt         = didx_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      step_r    <= '0;
      sub_r     <= '0;
      k_r       <= '0;
      didx_r    <= '0;
      quat_r[0] <= ONE_Q;
      quat_r[1] <= '0;
      quat_r[2] <= '0;
      quat_r[3] <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      sub_r   <= sub_nxt;
      k_r     <= k_nxt;
      didx_r  <= didx_nxt;
      quat_r  <= quat_nxt;
    end
    rate_r <= rate_nxt;
    dt_r   <= dt_nxt;
    h_r    <= h_nxt;
    nq_r   <= nq_nxt;
    mout_r <= mout_nxt;
  end

  // shared multiply-accumulate
  qgi_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .acc (acc)
  );

  // square root of the sum of squares
  qgi_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (acc[RAD_W-1:0]),
    .done     (sq_done),
    .root     (root)
  );

  // per-component divide by the norm
  qgi_div #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .mag   (mag_sh[didx_r]),
    .den   (root),
    .done  (dv_done),
    .quo   (quo)
  );

  // result beat
  always_comb begin
    for (int i = 0; i < N_ENTRIES; i++) begin
      out_tdata[i*QUAT_W +: QUAT_W] = mout_r[i];
    end
  end

endmodule

/* rtl/qgi_checker.sv */
// Port-level checker for the gyro integrator, bound to the top level.
`timescale 1ns / 1ps
module qgi_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [qgi_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import qgi_pkg::*;

  // never accepting while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while result pending");

  // one sample in flight: accepting closes the input side
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (!in_tready && !out_tvalid))
    else $error("block not busy after accepting a beat");

  // after a result beat the block returns to idle
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready) |=> (in_tready && !out_tvalid))
    else $error("block not idle after result beat");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind quaternion_gyro_integrator qgi_checker u_qgi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* sim/tb.sv */
// Testbench for quaternion_gyro_integrator: bit-exact rotation matrix checks on a tracked attitude.
`timescale 1ns / 1ps
module tb;
  import qgi_pkg::*;

  localparam int  FRAC       = 30;
  localparam int  RATE_MAX   = 2293760;
  localparam int  TAIL_WAIT  = 400;
  localparam int  CYCLE_CAP  = 5000000;
  localparam longint TINY_SUMSQ = 64'd1152921;

  typedef logic signed [127:0] wide_t;
  typedef logic [8:0][31:0] mat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  quaternion_gyro_integrator i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // attitude copy, identity after reset
  longint att_w = longint'(1) << FRAC;
  longint att_x = 0;
  longint att_y = 0;
  longint att_z = 0;

  mat_t   matrix_q[$];
  int     err_cnt = 0;
  int     tx_idle = 0;
  int     rx_idle = 0;
  longint cycle_cnt = 0;

  task automatic report(input string what);
    $display("mismatch: %s", what);
    err_cnt++;
  endtask

  function automatic longint half_angle(input logic signed [RATE_W-1:0] raw,
                                        input logic [DT_W-1:0] dt);
    longint r;
    r = raw;
    if (r > RATE_MAX) r = RATE_MAX;
    if (r < -RATE_MAX) r = -RATE_MAX;
    return (r * longint'(dt) + 1024) >>> 11;
  endfunction

  function automatic longint tri_dot(input longint a0, b0, a1, b1, a2, b2);
    wide_t s;
    s = wide_t'(a0) * wide_t'(b0) + wide_t'(a1) * wide_t'(b1) + wide_t'(a2) * wide_t'(b2);
    return longint'(s >>> FRAC);
  endfunction

  function automatic logic [31:0] to_entry(input wide_t v);
    wide_t e;
    e = (v + (wide_t'(1) << (FRAC - 1))) >>> FRAC;
    if (e > (wide_t'(1) << FRAC)) e = wide_t'(1) << FRAC;
    if (e < -(wide_t'(1) << FRAC)) e = -(wide_t'(1) << FRAC);
    return e[31:0];
  endfunction

  function automatic logic [127:0] floor_sqrt(input logic [127:0] v);
    logic [127:0] r, t;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // integrate one gyro sample, renormalize, build the rotation matrix
  function automatic mat_t integrate_sample(input logic [IN_TDATA_W-1:0] d);
    longint hx, hy, hz, w, x, y, z;
    longint nq[4];
    logic [127:0] mag[4];
    logic [127:0] mx, sum, n, qm;
    int k;
    wide_t ww, xx, yy, zz;
    mat_t m;
    hx = half_angle(d[22:0], d[92:69]);
    hy = half_angle(d[45:23], d[92:69]);
    hz = half_angle(d[68:46], d[92:69]);
    w = att_w; x = att_x; y = att_y; z = att_z;
    nq[0] = w + tri_dot(-x, hx, -y, hy, -z, hz);
    nq[1] = x + tri_dot(w, hx, y, hz, -z, hy);
    nq[2] = y + tri_dot(w, hy, -x, hz, z, hx);
    nq[3] = z + tri_dot(w, hz, x, hy, -y, hx);
    mx = '0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = (nq[i] < 0) ? 128'(-nq[i]) : 128'(nq[i]);
      if (mag[i] > mx) mx = mag[i];
    end
    k = 0;
    while ((mx >> k) >= (128'd1 << 31)) k++;
    sum = '0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = mag[i] >> k;
      sum += mag[i] * mag[i];
    end
    // tiny norm keeps the stored attitude
    if (k != 0 || sum > TINY_SUMSQ) begin
      n = floor_sqrt(sum);
      for (int i = 0; i < 4; i++) begin
        qm = ((mag[i] << FRAC) + (n >> 1)) / n;
        nq[i] = (nq[i] < 0) ? -longint'(qm) : longint'(qm);
      end
      att_w = nq[0]; att_x = nq[1]; att_y = nq[2]; att_z = nq[3];
    end
    ww = att_w; xx = att_x; yy = att_y; zz = att_z;
    m[0] = to_entry(ww * ww + xx * xx - yy * yy - zz * zz);
    m[1] = to_entry(2 * (xx * yy - ww * zz));
    m[2] = to_entry(2 * (xx * zz + ww * yy));
    m[3] = to_entry(2 * (xx * yy + ww * zz));
    m[4] = to_entry(ww * ww - xx * xx + yy * yy - zz * zz);
    m[5] = to_entry(2 * (yy * zz - ww * xx));
    m[6] = to_entry(2 * (xx * zz - ww * yy));
    m[7] = to_entry(2 * (yy * zz + ww * xx));
    m[8] = to_entry(ww * ww - xx * xx - yy * yy + zz * zz);
    return m;
  endfunction

  // send one gyro sample beat; valid stays high into the next beat unless a gap follows
  task automatic send_sample(input logic [RATE_W-1:0] rx, ry, rz, input logic [DT_W-1:0] dt);
    logic [IN_TDATA_W-1:0] d;
    if ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle) @(posedge clk);
    end
    d = {3'b000, dt, rz, ry, rx};
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    matrix_q.push_back(integrate_sample(d));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (matrix_q.size() != 0) @(posedge clk);
  endtask

  // result beat checker
  always @(posedge clk) begin
    mat_t got, want;
    out_tready <= ($urandom_range(99) >= rx_idle);
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (matrix_q.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        want = matrix_q.pop_front();
        for (int i = 0; i < 9; i++)
          if (got[i] !== want[i])
            report($sformatf("m%0d%0d got %h want %h", i / 3, i % 3, got[i], want[i]));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [RATE_W-1:0] rand_rate();
    if ($urandom_range(99) < 70)
      return RATE_W'(int'($urandom_range(2 * RATE_MAX)) - RATE_MAX);
    return RATE_W'($urandom());
  endfunction

  function automatic logic [DT_W-1:0] rand_dt();
    int sel;
    sel = $urandom_range(99);
    if (sel < 50) return DT_W'($urandom_range(1 << 15));
    if (sel < 70) return DT_W'($urandom_range(255));
    return DT_W'($urandom());
  endfunction

  // edges of the fields, zero step, saturation
  task automatic test_directed();
    logic [RATE_W-1:0] pmax, nmax;
    pmax = RATE_W'(RATE_MAX);
    nmax = RATE_W'(-RATE_MAX);
    send_sample('0, '0, '0, '0);
    send_sample(pmax, '0, '0, 24'd16777);
    send_sample('0, pmax, '0, 24'd16777);
    send_sample('0, '0, pmax, 24'd16777);
    send_sample(nmax, nmax, nmax, 24'hFFFFFF);
    send_sample(pmax, pmax, pmax, 24'hFFFFFF);
    send_sample(pmax, nmax, pmax, 24'h800000);
    send_sample('0, '0, '0, 24'hFFFFFF);
    send_sample(23'h1, 23'h7FFFFF, 23'h1, 24'h000001);
    send_sample(23'h3FFFFF, 23'h3FFFFF, 23'h3FFFFF, 24'hFFFFFF);
    send_sample(23'h400000, 23'h400000, 23'h400000, 24'hFFFFFF);
    send_sample(23'h3FFFFF, 23'h400000, 23'h2AAAAA, 24'h555555);
    send_sample(23'h555555, 23'h2AAAAA, 23'h7FFFFF, 24'hAAAAAA);
    send_sample(RATE_W'(RATE_MAX + 1), RATE_W'(-RATE_MAX - 1), '0, 24'h100000);
    send_sample('0, '0, '0, '0);
    send_sample(23'h000100, 23'h7FFF00, 23'h000080, 24'h004000);
  endtask

  task automatic test_random(input int count, input int tx_pct, input int rx_pct);
    tx_idle = tx_pct;
    rx_idle = rx_pct;
    for (int i = 0; i < count; i++) send_sample(rand_rate(), rand_rate(), rand_rate(), rand_dt());
  endtask

  // hold off until every matrix is back, then resume with the same idling
  task automatic test_drain_pause();
    wait_drained();
    test_random(20, tx_idle, rx_idle);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(480, 31, 50);
    test_drain_pause();
    test_random(480, 50, 31);
    test_random(470, 0, 0);
    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    if (err_cnt == 0 && matrix_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
